[design/softmax_forward_backward_unit_defines.svh]
// assertion macros shared by the softmax unit
`ifndef SOFTMAX_FORWARD_BACKWARD_UNIT_DEFINES_SVH
`define SOFTMAX_FORWARD_BACKWARD_UNIT_DEFINES_SVH

// same-cycle implication
`define SFB_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("softmax unit check failed");

// next-cycle implication
`define SFB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("softmax unit check failed");

`endif

[design/sfb_pkg.sv]
// types, codes and exp tables of the softmax unit
package sfb_pkg;

  localparam int PROB_W       = 16;
  localparam int EXP_W        = 17;
  localparam int RECIP_W      = 17;
  localparam int MUL_A_W      = 32;
  localparam int MUL_B_W      = 17;
  localparam int MUL_P_W      = MUL_A_W + MUL_B_W;
  localparam int DIVIDEND_MSB = 32;
  localparam int STEP_W       = 6;

  localparam logic [1:0] ACT_KEEP  = 2'd0;
  localparam logic [1:0] ACT_INFER = 2'd1;
  localparam logic [1:0] ACT_BACK  = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LONG     = 2'd1;
  localparam logic [1:0] ERR_MISMATCH = 2'd2;

  localparam logic KIND_PROB = 1'b0;
  localparam logic KIND_GRAD = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_DECIDE, S_ERR,
    S_EXP_RD, S_EXP_D, S_EXP_M1, S_EXP_R1, S_EXP_M2, S_EXP_R2, S_EXP_WR,
    S_DIV, S_P_RD, S_P_MUL, S_P_OUT,
    S_DOT_RD, S_DOT_ABS, S_DOT_MUL, S_DOT_ACC,
    S_G_RD, S_G_DIFF, S_G_MAG, S_G_MLO, S_G_MHI, S_G_SUM, S_G_OUT
  } state_t;

  typedef struct packed {
    logic               go;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  // e^-n scaled by 65536, zero from n = 12
  function automatic logic [EXP_W-1:0] exp_int(input logic [3:0] n);
    logic [EXP_W-1:0] r;
    unique case (n)
      4'd0:    r = 17'd65536;
      4'd1:    r = 17'd24109;
      4'd2:    r = 17'd8869;
      4'd3:    r = 17'd3263;
      4'd4:    r = 17'd1200;
      4'd5:    r = 17'd442;
      4'd6:    r = 17'd162;
      4'd7:    r = 17'd60;
      4'd8:    r = 17'd22;
      4'd9:    r = 17'd8;
      4'd10:   r = 17'd3;
      4'd11:   r = 17'd1;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

  // e^-(a/16) scaled by 65536
  function automatic logic [EXP_W-1:0] exp_hi(input logic [3:0] a);
    logic [EXP_W-1:0] r;
    unique case (a)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd61565;
      4'd2:  r = 17'd57835;
      4'd3:  r = 17'd54331;
      4'd4:  r = 17'd51039;
      4'd5:  r = 17'd47947;
      4'd6:  r = 17'd45042;
      4'd7:  r = 17'd42313;
      4'd8:  r = 17'd39750;
      4'd9:  r = 17'd37341;
      4'd10: r = 17'd35079;
      4'd11: r = 17'd32954;
      4'd12: r = 17'd30957;
      4'd13: r = 17'd29081;
      4'd14: r = 17'd27319;
      4'd15: r = 17'd25664;
    endcase
    return r;
  endfunction

  // e^-(b/256) scaled by 65536
  function automatic logic [EXP_W-1:0] exp_lo(input logic [3:0] b);
    logic [EXP_W-1:0] r;
    unique case (b)
      4'd0:  r = 17'd65536;
      4'd1:  r = 17'd65280;
      4'd2:  r = 17'd65026;
      4'd3:  r = 17'd64772;
      4'd4:  r = 17'd64520;
      4'd5:  r = 17'd64268;
      4'd6:  r = 17'd64018;
      4'd7:  r = 17'd63768;
      4'd8:  r = 17'd63520;
      4'd9:  r = 17'd63272;
      4'd10: r = 17'd63025;
      4'd11: r = 17'd62780;
      4'd12: r = 17'd62535;
      4'd13: r = 17'd62291;
      4'd14: r = 17'd62048;
      4'd15: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

[design/softmax_forward_backward_unit.sv]
// softmax unit: forward probabilities and backward gradients over one shared multiplier
//
// Input items (action, value, last) arrive on in_valid/in_ready and build one vector.
// Each element item is taken in one cycle while gathering. The item with last set starts
// the pass and in_ready stays low until the last result of that vector has been handed to
// the output register.
// Forward: the exp of each element (two table multiplies on the shared multiplier), then the
// reciprocal divider, then the emitted probabilities one by one.
// Backward: the dot product over the elements, then the emitted gradients one by one
// (the wide scale is split into two passes through the 32x17 multiplier).
// Error results are loaded from S_ERR, which follows S_DECIDE after the last item.
// Results leave through one output register on out_valid/out_ready; a stalled receiver
// holds the sequencer at the next result, nothing is dropped.
// Reset empties the gathered vector and the kept probabilities; the rams need no clearing
// since only entries below the counts are ever read.
`include "softmax_forward_backward_unit_defines.svh"

module softmax_forward_backward_unit #(
  parameter int MAX_FEATURES = 64,
  parameter int VALUE_BITS   = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         action,
  input  logic signed [VALUE_BITS-1:0]       value,
  input  logic                               last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               kind,
  output logic [sfb_pkg::PROB_W-1:0]         probability,
  output logic signed [VALUE_BITS-1:0]       gradient,
  output logic [1:0]                         error,
  output logic                               last_out
);

  import sfb_pkg::*;

  localparam int CNT_W  = $clog2(MAX_FEATURES + 1);
  localparam int IDX_W  = $clog2(MAX_FEATURES);
  localparam int SUM_W  = EXP_W + IDX_W;
  localparam int DOT_W  = VALUE_BITS + 17 + IDX_W;
  localparam int DIFF_W = DOT_W + 1;
  localparam int MAG_W  = DIFF_W - 8;
  localparam int GP_W   = MAG_W + 16;
  localparam int GM_W   = GP_W - 23;
  localparam int PH_W   = MUL_P_W + 1 - 16;

  localparam logic signed [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [GM_W-1:0] GM_NEG_MAX = GM_W'(64'd1 << (VALUE_BITS - 1));
  localparam logic [GM_W-1:0] GM_POS_MAX = GM_W'((64'd1 << (VALUE_BITS - 1)) - 64'd1);

  state_t state, state_next;

  logic [CNT_W-1:0]             elem_count;
  logic [CNT_W-1:0]             kept_count;
  logic signed [VALUE_BITS-1:0] run_max;
  logic                         overflow;
  logic [1:0]                   act_l;
  logic [1:0]                   err_code;
  logic [IDX_W-1:0]             idx;
  logic [SUM_W-1:0]             sum;
  logic [SUM_W-1:0]             sum_next;
  logic [RECIP_W-1:0]           recip;
  logic [VALUE_BITS-1:0]        d_reg;
  logic                         e_zero;
  logic [EXP_W-1:0]             e_reg;
  logic [EXP_W-1:0]             e_fin;
  logic [VALUE_BITS-1:0]        gabs;
  logic                         gneg;
  logic signed [DOT_W-1:0]      dot;
  logic signed [DOT_W-1:0]      dterm;
  logic signed [DIFF_W-1:0]     diff;
  logic [DIFF_W:0]              dx;
  logic [DIFF_W:0]              mrnd;
  logic [MAG_W-1:0]             mag;
  logic                         mneg;
  logic [63:0]                  mag_x;
  logic [MUL_P_W-1:0]           plo;
  logic [GP_W-1:0]              gprod;
  logic [GP_W:0]                gp_rnd;
  logic [GM_W-1:0]              gm;
  logic signed [VALUE_BITS-1:0] gout;

  logic signed [VALUE_BITS:0]   dd;
  logic [VALUE_BITS-1:0]        d_new;
  logic [VALUE_BITS-1:0]        d_hi;

  logic [MUL_P_W:0]             p_rnd;
  logic [PH_W-1:0]              p_hi;
  logic [PROB_W-1:0]            p_sat;

  mul_req_t                     mreq;
  logic [MUL_P_W-1:0]           mul_p;
  logic [63:0]                  mul_px;

  logic                         div_start;
  logic                         div_busy;
  logic [RECIP_W-1:0]           div_q;

  logic                         accept;
  logic                         elem_we;
  logic                         elem_re;
  logic                         exp_we;
  logic                         exp_re;
  logic                         kept_we;
  logic                         kept_re;
  logic                         out_load;
  logic                         slot_free;
  logic                         last_idx;
  logic                         finish;

  logic [VALUE_BITS-1:0]        elem_rd;
  logic [EXP_W-1:0]             exp_rd;
  logic [PROB_W-1:0]            kept_rd;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready && (action != ACT_NONE);
  assign elem_we   = accept && (elem_count < CNT_W'(MAX_FEATURES));
  assign slot_free = !out_valid || out_ready;
  assign last_idx  = (idx == IDX_W'(elem_count - CNT_W'(1)));

  assign dd     = {run_max[VALUE_BITS-1], run_max} - {elem_rd[VALUE_BITS-1], elem_rd};
  assign d_new  = dd[VALUE_BITS-1:0];
  assign d_hi   = d_reg >> 8;
  assign e_fin  = e_zero ? '0 : e_reg;
  assign sum_next = sum + SUM_W'(e_fin);

  assign p_rnd  = {1'b0, mul_p} + (MUL_P_W+1)'(32768);
  assign p_hi   = p_rnd[MUL_P_W:16];
  assign p_sat  = (|p_hi[PH_W-1:PROB_W]) ? {PROB_W{1'b1}} : p_hi[PROB_W-1:0];

  assign mul_px = 64'(mul_p);
  assign dterm  = $signed({1'b0, mul_px[DOT_W-2:0]});

  assign dx     = {diff[DIFF_W-1], diff};
  assign mrnd   = diff[DIFF_W-1] ? (DIFF_W+1)'(128) - dx : dx + (DIFF_W+1)'(128);
  assign mag_x  = 64'(mag);

  assign gp_rnd = {1'b0, gprod} + (GP_W+1)'(64'd1 << 23);
  assign gm     = gp_rnd[GP_W:24];
  always_comb begin
    if (mneg) begin
      gout = (gm >= GM_NEG_MAX) ? VMIN : $signed(-gm[VALUE_BITS-1:0]);
    end else begin
      gout = (gm > GM_POS_MAX) ? VMAX : $signed(gm[VALUE_BITS-1:0]);
    end
  end

  sfb_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_FEATURES)) u_elem_ram (
    .clk   (clk),
    .we    (elem_we),
    .waddr (elem_count[IDX_W-1:0]),
    .wdata (value),
    .re    (elem_re),
    .raddr (idx),
    .rdata (elem_rd)
  );

  sfb_ram #(.WIDTH(EXP_W), .DEPTH(MAX_FEATURES)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (idx),
    .wdata (e_fin),
    .re    (exp_re),
    .raddr (idx),
    .rdata (exp_rd)
  );

  sfb_ram #(.WIDTH(PROB_W), .DEPTH(MAX_FEATURES)) u_kept_ram (
    .clk   (clk),
    .we    (kept_we),
    .waddr (idx),
    .wdata (p_sat),
    .re    (kept_re),
    .raddr (idx),
    .rdata (kept_rd)
  );

  sfb_mul u_mul (
    .clk (clk),
    .req (mreq),
    .p   (mul_p)
  );

  sfb_div #(.SUM_W(SUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .den   (sum_next),
    .busy  (div_busy),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mreq       = '0;
    elem_re    = 1'b0;
    exp_re     = 1'b0;
    kept_re    = 1'b0;
    exp_we     = 1'b0;
    kept_we    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    finish     = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (overflow) begin
          state_next = S_ERR;
        end else if (act_l != ACT_BACK) begin
          state_next = S_EXP_RD;
        end else if (kept_count == '0 || kept_count != elem_count) begin
          state_next = S_ERR;
        end else begin
          state_next = S_DOT_RD;
        end
      end
      S_ERR: begin
        if (slot_free) begin
          out_load   = 1'b1;
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EXP_RD: begin
        elem_re    = 1'b1;
        state_next = S_EXP_D;
      end
      S_EXP_D: state_next = S_EXP_M1;
      S_EXP_M1: begin
        mreq.go    = 1'b1;
        mreq.a     = MUL_A_W'(exp_int(d_hi[3:0]));
        mreq.b     = exp_hi(d_reg[7:4]);
        state_next = S_EXP_R1;
      end
      S_EXP_R1: state_next = S_EXP_M2;
      S_EXP_M2: begin
        mreq.go    = 1'b1;
        mreq.a     = MUL_A_W'(e_reg);
        mreq.b     = exp_lo(d_reg[3:0]);
        state_next = S_EXP_R2;
      end
      S_EXP_R2: state_next = S_EXP_WR;
      S_EXP_WR: begin
        exp_we = 1'b1;
        if (last_idx) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_EXP_RD;
        end
      end
      S_DIV: begin
        if (!div_busy) begin
          state_next = S_P_RD;
        end
      end
      S_P_RD: begin
        exp_re     = 1'b1;
        state_next = S_P_MUL;
      end
      S_P_MUL: begin
        mreq.go    = 1'b1;
        mreq.a     = MUL_A_W'(exp_rd);
        mreq.b     = recip;
        state_next = S_P_OUT;
      end
      S_P_OUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          kept_we  = (act_l == ACT_KEEP);
          if (last_idx) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_P_RD;
          end
        end
      end
      S_DOT_RD: begin
        elem_re    = 1'b1;
        kept_re    = 1'b1;
        state_next = S_DOT_ABS;
      end
      S_DOT_ABS: state_next = S_DOT_MUL;
      S_DOT_MUL: begin
        mreq.go    = 1'b1;
        mreq.a     = MUL_A_W'(gabs);
        mreq.b     = MUL_B_W'(kept_rd);
        state_next = S_DOT_ACC;
      end
      S_DOT_ACC: state_next = last_idx ? S_G_RD : S_DOT_RD;
      S_G_RD: begin
        elem_re    = 1'b1;
        kept_re    = 1'b1;
        state_next = S_G_DIFF;
      end
      S_G_DIFF: state_next = S_G_MAG;
      S_G_MAG:  state_next = S_G_MLO;
      S_G_MLO: begin
        mreq.go    = 1'b1;
        mreq.a     = mag_x[31:0];
        mreq.b     = MUL_B_W'(kept_rd);
        state_next = S_G_MHI;
      end
      S_G_MHI: begin
        mreq.go    = 1'b1;
        mreq.a     = mag_x[63:32];
        mreq.b     = MUL_B_W'(kept_rd);
        state_next = S_G_SUM;
      end
      S_G_SUM: state_next = S_G_OUT;
      S_G_OUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (last_idx) begin
            finish     = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_G_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      kept_count <= '0;
      run_max    <= VMIN;
      overflow   <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (elem_we) begin
          elem_count <= elem_count + 1'b1;
          if (value > run_max) begin
            run_max <= value;
          end
        end else begin
          overflow <= 1'b1;
        end
      end
      if (state == S_DECIDE && overflow && act_l == ACT_KEEP) begin
        kept_count <= '0;
      end
      if (state == S_P_OUT && finish && act_l == ACT_KEEP) begin
        kept_count <= elem_count;
      end
      if ((state == S_EXP_WR || state == S_DOT_ACC ||
           (state == S_P_OUT && out_load) || (state == S_G_OUT && out_load))) begin
        idx <= last_idx ? '0 : idx + 1'b1;
      end
      if (state == S_IDLE) begin
        idx <= '0;
      end
      if (finish) begin
        elem_count <= '0;
        run_max    <= VMIN;
        overflow   <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept && last) begin
          act_l <= action;
        end
      end
      S_DECIDE: begin
        sum      <= '0;
        dot      <= '0;
        err_code <= overflow ? ERR_LONG : ERR_MISMATCH;
      end
      S_EXP_D: begin
        d_reg  <= d_new;
        e_zero <= (d_new >> 8) >= VALUE_BITS'(12);
      end
      S_EXP_R1, S_EXP_R2: e_reg <= p_hi[EXP_W-1:0];
      S_EXP_WR: sum <= sum_next;
      S_DIV: recip <= div_q;
      S_DOT_ABS: begin
        gneg <= elem_rd[VALUE_BITS-1];
        gabs <= elem_rd[VALUE_BITS-1] ? VALUE_BITS'(-elem_rd) : elem_rd;
      end
      S_DOT_ACC: dot <= gneg ? dot - dterm : dot + dterm;
      S_G_DIFF: begin
        diff <= $signed({{(DIFF_W-VALUE_BITS-16){elem_rd[VALUE_BITS-1]}}, elem_rd, 16'b0})
              - $signed({dot[DOT_W-1], dot});
      end
      S_G_MAG: begin
        mag  <= mrnd[DIFF_W-1:8];
        mneg <= diff[DIFF_W-1];
      end
      S_G_MHI: plo <= mul_p;
      S_G_SUM: gprod <= GP_W'({mul_p, 32'b0}) + GP_W'(plo);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (state)
        S_P_OUT: begin
          kind        <= KIND_PROB;
          probability <= p_sat;
          gradient    <= '0;
          error       <= ERR_NONE;
          last_out    <= last_idx;
        end
        S_G_OUT: begin
          kind        <= KIND_GRAD;
          probability <= '0;
          gradient    <= gout;
          error       <= ERR_NONE;
          last_out    <= last_idx;
        end
        default: begin
          kind        <= (act_l == ACT_BACK) ? KIND_GRAD : KIND_PROB;
          probability <= '0;
          gradient    <= '0;
          error       <= err_code;
          last_out    <= 1'b1;
        end
      endcase
    end
  end

  `SFB_ASSERT_HOLDS(a_err_single, out_valid && error != ERR_NONE, last_out && probability == '0 && gradient == '0)
  `SFB_ASSERT_HOLDS(a_prob_no_grad, out_valid && kind == KIND_PROB, gradient == '0)
  `SFB_ASSERT_NEXT(a_div_done, state == S_DIV && !div_busy, state == S_P_RD)
  `SFB_ASSERT_HOLDS(a_count_cap, 1'b1, elem_count <= CNT_W'(MAX_FEATURES))

endmodule

[design/sfb_ram.sv]
// generic single-port-write ram with registered read
module sfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sfb_mul.sv]
// shared registered multiplier
module sfb_mul (
  input  logic                         clk,
  input  sfb_pkg::mul_req_t            req,
  output logic [sfb_pkg::MUL_P_W-1:0]  p
);

  import sfb_pkg::*;

  always_ff @(posedge clk) begin
    if (req.go) begin
      p <= MUL_P_W'(req.a) * MUL_P_W'(req.b);
    end
  end

endmodule

[design/sfb_div.sv]
// bit-serial reciprocal divider, 2^32 over the exp sum
module sfb_div #(
  parameter int SUM_W = 23
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [SUM_W-1:0]             den,
  output logic                         busy,
  output logic [sfb_pkg::RECIP_W-1:0]  q
);

  import sfb_pkg::*;

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dsr;
  logic [STEP_W-1:0] step;
  logic [SUM_W:0]    sh;
  logic              ge;

  assign sh = {rem, step == STEP_W'(DIVIDEND_MSB)};
  assign ge = sh >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(DIVIDEND_MSB);
      rem  <= '0;
      q    <= '0;
      dsr  <= den;
    end else if (busy) begin
      rem  <= ge ? SUM_W'(sh - {1'b0, dsr}) : sh[SUM_W-1:0];
      q    <= {q[RECIP_W-2:0], ge};
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

endmodule
